@@ hw/rtl/plsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsa_pkg
// Shared types and constants of the posting list score accumulator: the
// command and result structs, command kinds and score limits.
// ----------------------------------------------------------------------------
package plsa_pkg;

    localparam int DOC_COUNT_DEF = 65536;
    localparam int SCORE_W       = 48;
    localparam int VAL_W         = 16;
    localparam int PROD_W        = 2 * VAL_W;

    localparam logic KIND_ACC  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    typedef struct packed {
        logic                    kind;
        logic [15:0]             doc_index;
        logic signed [VAL_W-1:0] entry_value;
        logic signed [VAL_W-1:0] term_weight;
        logic                    end_of_list;
    } t_cmd;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      list_done;
    } t_result;

endpackage

@@ hw/rtl/posting_list_score_accumulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// posting_list_score_accumulator
// Scatter-accumulate of weighted posting entries into a per-document score
// memory, with score readback.
// ----------------------------------------------------------------------------
// After reset the block zeroes its score memory, one entry per cycle, and
// holds busy high until every entry is cleared. After that busy stays low
// and one command is taken every cycle. A command is the edge with start
// high and busy low. Each command reaches its result in order: the memory
// read and the 16x16 product are registered first, then come the forwarded
// saturating add and the write back, then the result register. A read, or
// an accumulate that ends a posting list, strobes o_valid for one cycle
// and the result must be taken then; other accumulates give no result.
// Back-to-back updates of the same document are forwarded, so they add up.
module posting_list_score_accumulator #(
    parameter int DOC_COUNT = plsa_pkg::DOC_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  plsa_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    output plsa_pkg::t_result o_result
);

    localparam int ADDR_W = $clog2(DOC_COUNT);
    localparam int SUM_W  = plsa_pkg::SCORE_W + 1;

    logic                                accept;
    logic [ADDR_W+15:0]                  idx_ext;
    logic [ADDR_W-1:0]                   in_addr;
    logic                                in_range;
    logic                                clearing;
    logic signed [plsa_pkg::SCORE_W-1:0] rd_data;

    logic                                r_s1_valid;
    logic                                r_s1_kind;
    logic                                r_s1_eol;
    logic                                r_s1_in_range;
    logic [ADDR_W-1:0]                   r_s1_addr;
    logic signed [plsa_pkg::PROD_W-1:0]  r_s1_prod;
    logic                                r_fwd_hit;
    logic signed [plsa_pkg::SCORE_W-1:0] r_fwd_data;

    logic signed [plsa_pkg::SCORE_W-1:0] base;
    logic [SUM_W-1:0]                    sum;
    logic signed [plsa_pkg::SCORE_W-1:0] upd_score;
    logic                                s1_wr_en;

    logic                                r_out_valid;
    plsa_pkg::t_result                   r_out;
    logic                                n_out_valid;
    plsa_pkg::t_result                   n_out;

    assign accept   = start & ~busy;
    assign idx_ext  = {ADDR_W'(0), i_cmd.doc_index};
    assign in_addr  = idx_ext[ADDR_W-1:0];
    assign in_range = ({16'd0, i_cmd.doc_index} < 32'(DOC_COUNT));

    plsa_store #(
        .DOC_COUNT (DOC_COUNT),
        .ADDR_W    (ADDR_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (in_addr),
        .o_rd_data  (rd_data),
        .i_wr_en    (s1_wr_en),
        .i_wr_addr  (r_s1_addr),
        .i_wr_data  (upd_score),
        .o_clearing (clearing)
    );

    assign busy = clearing;

    // stage 1: forwarded base plus product, saturate, write back
    assign base     = r_fwd_hit ? r_fwd_data : rd_data;
    assign sum      = {base[plsa_pkg::SCORE_W-1], base}
                    + {{(SUM_W-plsa_pkg::PROD_W){r_s1_prod[plsa_pkg::PROD_W-1]}}, r_s1_prod};
    assign s1_wr_en = r_s1_valid & (r_s1_kind == plsa_pkg::KIND_ACC) & r_s1_in_range;

    always_comb begin
        if (sum[SUM_W-1] != sum[SUM_W-2]) begin
            upd_score = sum[SUM_W-1] ? plsa_pkg::SCORE_MIN : plsa_pkg::SCORE_MAX;
        end else begin
            upd_score = sum[plsa_pkg::SCORE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind     <= i_cmd.kind;
            r_s1_eol      <= i_cmd.end_of_list;
            r_s1_in_range <= in_range;
            r_s1_addr     <= in_addr;
            r_s1_prod     <= i_cmd.entry_value * i_cmd.term_weight;
            r_fwd_hit     <= s1_wr_en && (r_s1_addr == in_addr);
            r_fwd_data    <= upd_score;
        end
    end

    // result register
    always_comb begin
        n_out_valid = 1'b0;
        n_out       = '0;
        if (r_s1_valid) begin
            if (r_s1_kind == plsa_pkg::KIND_READ) begin
                n_out_valid = 1'b1;
                n_out.score = r_s1_in_range ? base : '0;
            end else if (r_s1_eol) begin
                n_out_valid     = 1'b1;
                n_out.list_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_valid)
        else $error("result transfer during clearing sweep");

    a_list_done_zero_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.list_done) |-> (o_result.score == '0))
        else $error("list done result with nonzero score");

    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.kind == plsa_pkg::KIND_READ)
            |=> ##1 (o_valid && !o_result.list_done))
        else $error("read command without score transfer");

    a_mid_list_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.kind == plsa_pkg::KIND_ACC && !i_cmd.end_of_list)
            |=> ##1 !o_valid)
        else $error("mid-list accumulate produced a transfer");
`endif

endmodule

@@ hw/rtl/plsa_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plsa_store
// Score memory with one read and one write port and a registered read.
// Sweeps zeros through every entry after reset and reports it as clearing.
// ----------------------------------------------------------------------------
module plsa_store #(
    parameter int DOC_COUNT = plsa_pkg::DOC_COUNT_DEF,
    parameter int ADDR_W    = $clog2(DOC_COUNT)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_rd_en,
    input  logic [ADDR_W-1:0]                 i_rd_addr,
    output logic signed [plsa_pkg::SCORE_W-1:0] o_rd_data,
    input  logic                              i_wr_en,
    input  logic [ADDR_W-1:0]                 i_wr_addr,
    input  logic signed [plsa_pkg::SCORE_W-1:0] i_wr_data,
    output logic                              o_clearing
);

    logic signed [plsa_pkg::SCORE_W-1:0] r_mem [DOC_COUNT];
    logic signed [plsa_pkg::SCORE_W-1:0] r_rd_data;
    logic                                r_clearing;
    logic                                n_clearing;
    logic [ADDR_W-1:0]                   r_clr_addr;
    logic [ADDR_W-1:0]                   n_clr_addr;
    logic                                wr_en;
    logic [ADDR_W-1:0]                   wr_addr;
    logic signed [plsa_pkg::SCORE_W-1:0] wr_data;

    // clearing sweep
    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(DOC_COUNT - 1)) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    assign wr_en   = r_clearing | i_wr_en;
    assign wr_addr = r_clearing ? r_clr_addr : i_wr_addr;
    assign wr_data = r_clearing ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule
